// ===== src/fats_pkg.sv =====
`default_nettype none
package fats_pkg;

	// sizing
	localparam int COUNT_WIDTH = 16;
	localparam int TIME_WIDTH  = 32;
	localparam int DSUM_W      = COUNT_WIDTH + 2;
	localparam int PROD_W      = DSUM_W + 4;
	localparam int WSUM_W      = (PROD_W + 2 > 25) ? PROD_W + 2 : 25;
	localparam int TOTAL_W     = 32;
	localparam int SUMT_W      = ((DSUM_W > TOTAL_W) ? DSUM_W : TOTAL_W) + 1;
	localparam int WDEL_W      = 18;
	localparam int WCMP_W      = (DSUM_W > WDEL_W) ? DSUM_W : WDEL_W;
	localparam int SCORE_W     = 24;
	localparam int SCALED_W    = 27;
	localparam int RECIP_W     = 28;
	localparam int RECIP_SHIFT = 30;
	localparam int PRODQ_W     = SCALED_W + RECIP_W;
	localparam int Q_W         = 25;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int ID_W        = 16;

	localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
	localparam logic [WDEL_W-1:0]  WDEL_MAX  = {WDEL_W{1'b1}};
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [7:0]         BURST_MAX = 8'hFF;
	// ceil(2^30 / 5): exact floor(x/5) for x below 2^30
	localparam logic [RECIP_W-1:0] RECIP_5   = 28'd214748365;

	// register reset values
	localparam logic [3:0]  WT_HI_RST         = 4'd5;
	localparam logic [3:0]  WT_MID_RST        = 4'd3;
	localparam logic [3:0]  WT_LO_RST         = 4'd1;
	localparam logic [23:0] SUSP_LEVEL_RST    = 24'd50;
	localparam logic [23:0] DESTR_LEVEL_RST   = 24'd150;
	localparam logic [7:0]  BURST_LIMIT_RST   = 8'd3;
	localparam logic [15:0] BURST_WINDOW_RST  = 16'd500;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;
	typedef logic [DSUM_W-1:0]      dsum_t;
	typedef logic [PROD_W-1:0]      prod_t;
	typedef logic [WSUM_W-1:0]      wsum_t;
	typedef logic [TIME_WIDTH-1:0]  time_t;
	typedef logic [SUMT_W-1:0]      sumt_t;
	typedef logic [WCMP_W-1:0]      wcmp_t;
	typedef logic [SCALED_W-1:0]    scaled_t;
	typedef logic [PRODQ_W-1:0]     prodq_t;
	typedef logic [Q_W-1:0]         q_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WT_HI,
		REG_WT_MID,
		REG_WT_LO,
		REG_SUSP_LEVEL,
		REG_DESTR_LEVEL,
		REG_BURST_LIMIT,
		REG_BURST_WINDOW
	} reg_idx_t;

	typedef enum logic {
		CMD_EVENT,
		CMD_TICK
	} cmd_t;

	typedef enum logic [1:0] {
		TIER_HIGH,
		TIER_MEDIUM,
		TIER_LOW
	} tier_t;

	typedef enum logic [1:0] {
		KIND_DELETE,
		KIND_MODIFY,
		KIND_RENAME,
		KIND_OTHER
	} kind_t;

	typedef enum logic [1:0] {
		LVL_NORMAL,
		LVL_SUSPICIOUS,
		LVL_DESTRUCTIVE
	} level_t;

	typedef struct packed {
		logic [3:0]  wt_hi;
		logic [3:0]  wt_mid;
		logic [3:0]  wt_lo;
		logic [23:0] suspicious_level;
		logic [23:0] destructive_level;
		logic [7:0]  burst_count_limit;
		logic [15:0] burst_window_ms;
	} cfg_t;

	typedef struct packed {
		logic        flag;
		logic [7:0]  count;
		logic [15:0] span;
	} burst_t;

	typedef struct packed {
		cmd_t                   kind;
		burst_t                 burst;
		logic [2:0][DSUM_W-1:0] tot;
		dsum_t                  dels;
		logic [2:0]             mask;
	} win_t;

	typedef struct packed {
		cmd_t                 kind;
		burst_t               burst;
		logic [SCORE_W-1:0]   wsum;
		logic                 over;
		logic                 spread;
		dsum_t                dels;
		logic [2:0]           mask;
	} mid_t;

	typedef struct packed {
		cmd_t       kind;
		burst_t     burst;
		q_t         q;
		logic       over;
		dsum_t      dels;
		logic [2:0] mask;
	} scl_t;

endpackage
`default_nettype wire

// ===== src/fats_if.sv =====
`default_nettype none
interface fats_event_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [1:0]  tier;
	logic [1:0]  event_kind;
	logic [31:0] time_ms;

	modport source(output valid, cmd, tier, event_kind, time_ms, input ready);
	modport sink(input valid, cmd, tier, event_kind, time_ms, output ready);
endinterface

interface fats_report_if;
	logic        valid;
	logic        ready;
	logic        report_kind;
	logic        burst_flag;
	logic [7:0]  burst_count;
	logic [15:0] burst_span_ms;
	logic [23:0] score;
	logic [1:0]  level;
	logic        new_alert;
	logic [15:0] alert_id;
	logic [2:0]  tiers_mask;
	logic [17:0] window_deletes;
	logic [31:0] lost_total;
	logic        escalation_flag;

	modport source(output valid, report_kind, burst_flag, burst_count, burst_span_ms, score,
		level, new_alert, alert_id, tiers_mask, window_deletes, lost_total,
		escalation_flag, input ready);
	modport sink(input valid, report_kind, burst_flag, burst_count, burst_span_ms, score,
		level, new_alert, alert_id, tiers_mask, window_deletes, lost_total,
		escalation_flag, output ready);
endinterface

interface fats_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [fats_pkg::CFG_IDX_W-1:0]   index;
	logic [fats_pkg::CFG_DATA_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/file_activity_threat_scorer.sv =====
`default_nettype none
// File activity threat scorer.
// events (sink): one word per file event (cmd 0) or window tick (cmd 1).
//   Events bump at most one of nine saturating per-tier/per-kind counters;
//   high-tier deletes also drive the burst detector. A tick reads and
//   clears the nine counters and produces a scored window report.
// reports (source): exactly one word per accepted events word, in order.
// cfg (sink): register writes by index (0..6 as listed in the register map),
//   always ready; an unknown index is dropped. Write only while idle.
// Throughput: one word per cycle while reports.ready stays high. A word
//   accepted passes five registers on its way to reports (input reg,
//   counter/burst stage, weighted-sum stage, 6/5 reciprocal-multiply stage,
//   level/alert stage). The counter and burst update sits in one stage and
//   the alert state in another, so each item sees its predecessor's state.
// Stall: every stage has its own valid bit and only moves when the next
//   stage is free, so bubbles collapse; events.ready drops only once all
//   five registers hold words and reports.ready is low. Held words stay put.
// Reset (arst_n low, async): registers to defaults, counters, burst
//   detector, alert state and delete total to zero, pipeline emptied.
//   No clearing pass: the block takes words as soon as reset is released.
module file_activity_threat_scorer (
	input  wire logic      clk,
	input  wire logic      arst_n,
	fats_event_if.sink     events,
	fats_report_if.source  reports,
	fats_cfg_if.sink       cfg
);

	fats_pkg::cfg_t  regs;

	// window stage -> score stages
	logic            valid_s2;
	logic            ready_s2;
	fats_pkg::win_t  win_s2;

	// score stages -> alert stage
	logic            valid_s4;
	logic            ready_s4;
	fats_pkg::scl_t  scl_s4;

	fats_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// input register, counters, burst detector
	fats_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.events   (events),
		.cfg      (regs),
		.valid_s2 (valid_s2),
		.ready_s2 (ready_s2),
		.win_s2   (win_s2)
	);

	// weighted sum, then spread scaling
	fats_score u_score (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (regs),
		.valid_s2 (valid_s2),
		.ready_s2 (ready_s2),
		.win_s2   (win_s2),
		.valid_s4 (valid_s4),
		.ready_s4 (ready_s4),
		.scl_s4   (scl_s4)
	);

	// level, alert tracking, totals, output register
	fats_alert u_alert (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (regs),
		.valid_s4 (valid_s4),
		.ready_s4 (ready_s4),
		.scl_s4   (scl_s4),
		.reports  (reports)
	);

endmodule
`default_nettype wire

// ===== src/fats_cfg.sv =====
`default_nettype none
module fats_cfg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	fats_cfg_if.sink            cfg,
	output fats_pkg::cfg_t      regs
);

	fats_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.wt_hi             <= fats_pkg::WT_HI_RST;
			regs_q.wt_mid            <= fats_pkg::WT_MID_RST;
			regs_q.wt_lo             <= fats_pkg::WT_LO_RST;
			regs_q.suspicious_level  <= fats_pkg::SUSP_LEVEL_RST;
			regs_q.destructive_level <= fats_pkg::DESTR_LEVEL_RST;
			regs_q.burst_count_limit <= fats_pkg::BURST_LIMIT_RST;
			regs_q.burst_window_ms   <= fats_pkg::BURST_WINDOW_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				fats_pkg::REG_WT_HI:         regs_q.wt_hi             <= cfg.data[3:0];
				fats_pkg::REG_WT_MID:        regs_q.wt_mid            <= cfg.data[3:0];
				fats_pkg::REG_WT_LO:         regs_q.wt_lo             <= cfg.data[3:0];
				fats_pkg::REG_SUSP_LEVEL:    regs_q.suspicious_level  <= cfg.data[23:0];
				fats_pkg::REG_DESTR_LEVEL:   regs_q.destructive_level <= cfg.data[23:0];
				fats_pkg::REG_BURST_LIMIT:   regs_q.burst_count_limit <= cfg.data[7:0];
				fats_pkg::REG_BURST_WINDOW:  regs_q.burst_window_ms   <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/fats_window.sv =====
`default_nettype none
module fats_window (
	input  wire logic           clk,
	input  wire logic           arst_n,
	fats_event_if.sink          events,
	input  fats_pkg::cfg_t      cfg,
	output logic                valid_s2,
	input  wire logic           ready_s2,
	output fats_pkg::win_t      win_s2
);

	logic                      v_s1;
	logic                      cmd_s1;
	logic [1:0]                tier_s1;
	logic [1:0]                kind_s1;
	fats_pkg::time_t           now_s1;

	logic [8:0][fats_pkg::COUNT_WIDTH-1:0] cnt_q;
	logic [7:0]                bd_q;
	fats_pkg::time_t           start_q;

	logic                      load2;
	logic                      fire1;
	logic                      tick;
	logic                      ev;
	logic [8:0]                hit;
	fats_pkg::time_t           start_eff;
	logic [7:0]                bd_inc;
	fats_pkg::time_t           span;
	logic                      in_window;
	logic                      burst_hit;
	fats_pkg::win_t            win_n;

	assign load2        = !valid_s2 || ready_s2;
	assign fire1        = v_s1 && load2;
	assign events.ready = !v_s1 || load2;

	assign tick = (cmd_s1 == fats_pkg::CMD_TICK);
	assign ev   = !tick;

	always_comb begin
		for (int t = 0; t < 3; t++) begin
			for (int k = 0; k < 3; k++) begin
				hit[t * 3 + k] = ev && (tier_s1 == 2'(t)) && (kind_s1 == 2'(k));
			end
		end
	end

	// burst detector, high-tier deletes only (hit[0])
	assign start_eff = (bd_q == 8'd0) ? now_s1 : start_q;
	assign bd_inc    = (bd_q != fats_pkg::BURST_MAX) ? bd_q + 8'd1 : bd_q;
	assign span      = now_s1 - start_eff;
	assign in_window = span <= fats_pkg::time_t'(cfg.burst_window_ms);
	assign burst_hit = hit[0] && (bd_inc >= cfg.burst_count_limit) && in_window;

	always_comb begin
		win_n             = '0;
		win_n.kind        = fats_pkg::cmd_t'(cmd_s1);
		win_n.burst.flag  = burst_hit;
		win_n.burst.count = burst_hit ? bd_inc : 8'd0;
		win_n.burst.span  = burst_hit ? span[15:0] : 16'd0;
		if (tick) begin
			for (int t = 0; t < 3; t++) begin
				win_n.tot[t] = fats_pkg::dsum_t'(cnt_q[t * 3])
					+ fats_pkg::dsum_t'(cnt_q[t * 3 + 1])
					+ fats_pkg::dsum_t'(cnt_q[t * 3 + 2]);
				win_n.mask[t] = (win_n.tot[t] != '0);
			end
			win_n.dels = fats_pkg::dsum_t'(cnt_q[0]) + fats_pkg::dsum_t'(cnt_q[3])
				+ fats_pkg::dsum_t'(cnt_q[6]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			valid_s2 <= 1'b0;
			cnt_q    <= '0;
			bd_q     <= 8'd0;
			start_q  <= '0;
		end else begin
			if (events.ready) begin
				v_s1 <= events.valid;
			end
			if (load2) begin
				valid_s2 <= v_s1;
			end
			if (fire1) begin
				for (int i = 0; i < 9; i++) begin
					if (tick) begin
						cnt_q[i] <= '0;
					end else if (hit[i] && (cnt_q[i] != '1)) begin
						cnt_q[i] <= cnt_q[i] + 1'b1;
					end
				end
				if (hit[0]) begin
					if (burst_hit) begin
						bd_q    <= 8'd0;
						start_q <= '0;
					end else if (!in_window) begin
						bd_q    <= 8'd1;
						start_q <= now_s1;
					end else begin
						bd_q    <= bd_inc;
						start_q <= start_eff;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (events.ready && events.valid) begin
			cmd_s1  <= events.cmd;
			tier_s1 <= events.tier;
			kind_s1 <= events.event_kind;
			now_s1  <= fats_pkg::time_t'(events.time_ms);
		end
		if (fire1) begin
			win_s2 <= win_n;
		end
	end

endmodule
`default_nettype wire

// ===== src/fats_score.sv =====
`default_nettype none
module fats_score (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  fats_pkg::cfg_t      cfg,
	input  wire logic           valid_s2,
	output logic                ready_s2,
	input  fats_pkg::win_t      win_s2,
	output logic                valid_s4,
	input  wire logic           ready_s4,
	output fats_pkg::scl_t      scl_s4
);

	logic                valid_s3;
	fats_pkg::mid_t      mid_s3;
	logic                load3;
	logic                load4;
	fats_pkg::prod_t     p_high;
	fats_pkg::prod_t     p_med;
	fats_pkg::prod_t     p_low;
	fats_pkg::wsum_t     wsum;
	fats_pkg::mid_t      mid_n;
	fats_pkg::scaled_t   x;
	fats_pkg::scaled_t   s_ext;
	fats_pkg::prodq_t    prodq;
	fats_pkg::scl_t      scl_n;

	assign load4    = !valid_s4 || ready_s4;
	assign load3    = !valid_s3 || load4;
	assign ready_s2 = load3;

	// weighted sum, cut to the score width with an overflow flag
	assign p_high = fats_pkg::prod_t'(win_s2.tot[0]) * fats_pkg::prod_t'(cfg.wt_hi);
	assign p_med  = fats_pkg::prod_t'(win_s2.tot[1]) * fats_pkg::prod_t'(cfg.wt_mid);
	assign p_low  = fats_pkg::prod_t'(win_s2.tot[2]) * fats_pkg::prod_t'(cfg.wt_lo);
	assign wsum   = fats_pkg::wsum_t'(p_high) + fats_pkg::wsum_t'(p_med)
		+ fats_pkg::wsum_t'(p_low);

	always_comb begin
		mid_n        = '0;
		mid_n.kind   = win_s2.kind;
		mid_n.burst  = win_s2.burst;
		mid_n.wsum   = wsum[fats_pkg::SCORE_W-1:0];
		mid_n.over   = wsum > fats_pkg::wsum_t'(fats_pkg::SCORE_MAX);
		mid_n.spread = (win_s2.mask[0] && win_s2.mask[1]) || (win_s2.mask[0] && win_s2.mask[2])
			|| (win_s2.mask[1] && win_s2.mask[2]);
		mid_n.dels   = win_s2.dels;
		mid_n.mask   = win_s2.mask;
	end

	// 6s/5 when spread, 5s/5 otherwise, through one reciprocal multiply
	assign s_ext = fats_pkg::scaled_t'(mid_s3.wsum);
	assign x     = mid_s3.spread ? (s_ext << 2) + (s_ext << 1) : (s_ext << 2) + s_ext;
	assign prodq = fats_pkg::prodq_t'(x) * fats_pkg::prodq_t'(fats_pkg::RECIP_5);

	always_comb begin
		scl_n       = '0;
		scl_n.kind  = mid_s3.kind;
		scl_n.burst = mid_s3.burst;
		scl_n.q     = prodq[fats_pkg::RECIP_SHIFT +: fats_pkg::Q_W];
		scl_n.over  = mid_s3.over;
		scl_n.dels  = mid_s3.dels;
		scl_n.mask  = mid_s3.mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (load3) begin
				valid_s3 <= valid_s2;
			end
			if (load4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load3 && valid_s2) begin
			mid_s3 <= mid_n;
		end
		if (load4 && valid_s3) begin
			scl_s4 <= scl_n;
		end
	end

endmodule
`default_nettype wire

// ===== src/fats_alert.sv =====
`default_nettype none
module fats_alert (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  fats_pkg::cfg_t      cfg,
	input  wire logic           valid_s4,
	output logic                ready_s4,
	input  fats_pkg::scl_t      scl_s4,
	fats_report_if.source       reports
);

	typedef struct packed {
		logic                            report_kind;
		fats_pkg::burst_t                burst;
		logic [fats_pkg::SCORE_W-1:0]    score;
		fats_pkg::level_t                level;
		logic                            new_alert;
		logic [fats_pkg::ID_W-1:0]       alert_id;
		logic [2:0]                      tiers_mask;
		logic [fats_pkg::WDEL_W-1:0]     window_deletes;
		logic [fats_pkg::TOTAL_W-1:0]    lost_total;
		logic                            escalation_flag;
	} res_t;

	logic                            out_v_q;
	res_t                            res_q;
	logic                            alert_active_q;
	fats_pkg::level_t                last_level_q;
	logic [fats_pkg::ID_W-1:0]       alert_number_q;
	logic [fats_pkg::TOTAL_W-1:0]    deletes_total_q;
	logic                            escalated_q;

	logic                            load;
	logic                            fire;
	logic                            tick;
	logic [fats_pkg::SCORE_W-1:0]    score;
	fats_pkg::level_t                level;
	logic                            newa;
	logic                            active_n;
	fats_pkg::level_t                last_n;
	logic [fats_pkg::ID_W-1:0]       num_n;
	logic                            esc_n;
	fats_pkg::sumt_t                 tsum;
	logic [fats_pkg::TOTAL_W-1:0]    total_n;
	fats_pkg::wcmp_t                 dext;
	logic [fats_pkg::WDEL_W-1:0]     wdel;
	res_t                            res_n;

	assign load     = !out_v_q || reports.ready;
	assign fire     = valid_s4 && load;
	assign ready_s4 = load;
	assign tick     = (scl_s4.kind == fats_pkg::CMD_TICK);

	assign score = (scl_s4.over || (scl_s4.q > fats_pkg::q_t'(fats_pkg::SCORE_MAX)))
		? fats_pkg::SCORE_MAX : scl_s4.q[fats_pkg::SCORE_W-1:0];

	// destructive is tested first
	always_comb begin
		level = fats_pkg::LVL_NORMAL;
		if (tick) begin
			if (score >= cfg.destructive_level) begin
				level = fats_pkg::LVL_DESTRUCTIVE;
			end else if (score >= cfg.suspicious_level) begin
				level = fats_pkg::LVL_SUSPICIOUS;
			end
		end
	end

	always_comb begin
		newa     = 1'b0;
		active_n = alert_active_q;
		last_n   = last_level_q;
		num_n    = alert_number_q;
		esc_n    = escalated_q;
		if (tick) begin
			if (level == fats_pkg::LVL_DESTRUCTIVE) begin
				esc_n = 1'b1;
			end
			if (level != fats_pkg::LVL_NORMAL) begin
				if (!alert_active_q || (level != last_level_q)) begin
					newa     = 1'b1;
					active_n = 1'b1;
					last_n   = level;
					num_n    = alert_number_q + 1'b1;
				end
			end else begin
				active_n = 1'b0;
				last_n   = fats_pkg::LVL_NORMAL;
				esc_n    = 1'b0;
			end
		end
	end

	// running delete total, saturating; events carry zero deletes
	assign tsum    = fats_pkg::sumt_t'(deletes_total_q) + fats_pkg::sumt_t'(scl_s4.dels);
	assign total_n = (tsum > fats_pkg::sumt_t'(fats_pkg::TOTAL_MAX))
		? fats_pkg::TOTAL_MAX : tsum[fats_pkg::TOTAL_W-1:0];
	assign dext    = fats_pkg::wcmp_t'(scl_s4.dels);
	assign wdel    = (dext > fats_pkg::wcmp_t'(fats_pkg::WDEL_MAX))
		? fats_pkg::WDEL_MAX : dext[fats_pkg::WDEL_W-1:0];

	always_comb begin
		res_n                 = '0;
		res_n.report_kind     = scl_s4.kind;
		res_n.burst           = scl_s4.burst;
		res_n.score           = tick ? score : '0;
		res_n.level           = level;
		res_n.new_alert       = newa;
		res_n.alert_id        = num_n;
		res_n.tiers_mask      = scl_s4.mask;
		res_n.window_deletes  = wdel;
		res_n.lost_total      = total_n;
		res_n.escalation_flag = esc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q         <= 1'b0;
			alert_active_q  <= 1'b0;
			last_level_q    <= fats_pkg::LVL_NORMAL;
			alert_number_q  <= '0;
			deletes_total_q <= '0;
			escalated_q     <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= valid_s4;
			end
			if (fire) begin
				alert_active_q  <= active_n;
				last_level_q    <= last_n;
				alert_number_q  <= num_n;
				deletes_total_q <= total_n;
				escalated_q     <= esc_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_n;
		end
	end

	assign reports.valid           = out_v_q;
	assign reports.report_kind     = res_q.report_kind;
	assign reports.burst_flag      = res_q.burst.flag;
	assign reports.burst_count     = res_q.burst.count;
	assign reports.burst_span_ms   = res_q.burst.span;
	assign reports.score           = res_q.score;
	assign reports.level           = res_q.level;
	assign reports.new_alert       = res_q.new_alert;
	assign reports.alert_id        = res_q.alert_id;
	assign reports.tiers_mask      = res_q.tiers_mask;
	assign reports.window_deletes  = res_q.window_deletes;
	assign reports.lost_total      = res_q.lost_total;
	assign reports.escalation_flag = res_q.escalation_flag;

	a_id_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && newa |=> alert_number_q == $past(alert_number_q) + 1'b1)
		else $error("alert id did not advance on a new alert");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(alert_number_q) && $stable(deletes_total_q) && $stable(escalated_q))
		else $error("alert state changed without a word");

	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		deletes_total_q >= $past(deletes_total_q))
		else $error("delete total went down");

	a_esc_active: assert property (@(posedge clk) disable iff (!arst_n)
		escalated_q |-> alert_active_q)
		else $error("escalated without an active alert");

endmodule
`default_nettype wire

// ===== sim/file_activity_threat_scorer_tb.sv =====
module file_activity_threat_scorer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// tier code that maps to no counter; the block must ignore it
	localparam logic [1:0] TIER_NONE = 2'd3;
	// register index past the map; writes to it are dropped
	localparam logic [fats_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	// receiver hold-off, in cycles, and the report counts that trigger it
	localparam int LONG_HOLD = 90;
	localparam int HOLD_MARK_A = 40;
	localparam int HOLD_MARK_B = 300;
	// mismatch lines beyond this are counted but not printed
	localparam int PRINT_CAP = 40;

	// receiver behavior, redrawn at random whenever a mode runs out
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_MOSTLY,
		RX_TOGGLE
	} rx_mode_t;

	// one word waiting to go out on the events channel
	typedef struct packed {
		fats_pkg::cmd_t  cmd;
		logic [1:0]      tier;
		fats_pkg::kind_t kind;
		logic [31:0]     t_ms;
	} ev_word_t;

	// expected contents of one report word
	typedef struct packed {
		fats_pkg::cmd_t   kind;
		logic             bflag;
		logic [7:0]       bcount;
		logic [15:0]      bspan;
		logic [23:0]      score;
		fats_pkg::level_t level;
		logic             new_alert;
		logic [15:0]      alert_id;
		logic [2:0]       mask;
		logic [17:0]      wdel;
		logic [31:0]      lost;
		logic             esc;
	} report_word_t;

	logic clk;
	logic arst_n;

	fats_event_if  ev_if();
	fats_report_if rep_if();
	fats_cfg_if    cfg_if();

	file_activity_threat_scorer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.events (ev_if),
		.reports(rep_if),
		.cfg    (cfg_if)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------
	// Scoreboard state
	// ---------------------------------------------------------------
	ev_word_t     pending_words[$];  // words not yet accepted by the block
	report_word_t due_reports[$];    // forecast reports, oldest first
	int           fail_count;
	int           n_reports;
	logic         ev_fire;           // events handshake at the last rising edge
	logic [31:0]  now_ms;            // running stimulus timestamp

	// Shadow of the block: registers, counters, burst detector, alert tracking
	fats_pkg::cfg_t   regs;
	fats_pkg::cnt_t   win_count[9];
	logic [7:0]       rush_n;
	logic [31:0]      rush_t0;
	logic             alarm_on;
	fats_pkg::level_t alarm_level;
	logic [15:0]      alarm_seq;
	logic [31:0]      lost_sum;
	logic             escal;

	task automatic note_mismatch(input string msg);
		if (fail_count < PRINT_CAP)
			$display("mismatch @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			note_mismatch($sformatf("%s got 0x%0h want 0x%0h (report %0d)",
				name, got, want, n_reports));
	endtask

	// Works out the report for one accepted word and advances the shadow.
	function automatic report_word_t forecast_report(input fats_pkg::cmd_t cmd,
		input logic [1:0] tier, input fats_pkg::kind_t kind, input logic [31:0] t_ms);
		report_word_t    w;
		logic [31:0]     span;
		int unsigned     slot;
		longint unsigned tot[3];
		longint unsigned dels;
		longint unsigned sum;
		longint unsigned s;
		int              touched;
		w = '0;
		if (cmd == fats_pkg::CMD_EVENT) begin
			if (tier != TIER_NONE && kind != fats_pkg::KIND_OTHER) begin
				slot = tier * 3 + kind;
				if (win_count[slot] != '1)
					win_count[slot]++;
				if (tier == fats_pkg::TIER_HIGH && kind == fats_pkg::KIND_DELETE) begin
					// burst detector: first delete stamps the start time
					if (rush_n == 8'd0)
						rush_t0 = t_ms;
					if (rush_n != fats_pkg::BURST_MAX)
						rush_n++;
					span = t_ms - rush_t0;
					if (rush_n >= regs.burst_count_limit && span <= regs.burst_window_ms) begin
						w.bflag  = 1'b1;
						w.bcount = rush_n;
						w.bspan  = span[15:0];
						rush_n   = 8'd0;
						rush_t0  = '0;
					end
					// too slow: this delete opens a fresh run
					if (span > regs.burst_window_ms) begin
						rush_n  = 8'd1;
						rush_t0 = t_ms;
					end
				end
			end
		end else begin
			touched = 0;
			for (int i = 0; i < 3; i++) begin
				tot[i] = longint'(win_count[3*i]) + longint'(win_count[3*i+1]) +
					longint'(win_count[3*i+2]);
				if (tot[i] != 0) begin
					w.mask[i] = 1'b1;
					touched++;
				end
			end
			dels = longint'(win_count[0]) + longint'(win_count[3]) + longint'(win_count[6]);
			for (int i = 0; i < 9; i++)
				win_count[i] = '0;
			w.wdel = (dels > fats_pkg::WDEL_MAX) ? fats_pkg::WDEL_MAX : dels[17:0];
			sum = longint'(lost_sum) + dels;
			lost_sum = (sum > fats_pkg::TOTAL_MAX) ? fats_pkg::TOTAL_MAX : sum[31:0];

			s = tot[0] * regs.wt_hi + tot[1] * regs.wt_mid + tot[2] * regs.wt_lo;
			// spread over two or more tiers: x6/5, floor
			if (touched >= 2)
				s = (s * 6) / 5;
			w.score = (s > fats_pkg::SCORE_MAX) ? fats_pkg::SCORE_MAX : s[23:0];

			// destructive wins even when the thresholds are crossed
			if (w.score >= regs.destructive_level)
				w.level = fats_pkg::LVL_DESTRUCTIVE;
			else if (w.score >= regs.suspicious_level)
				w.level = fats_pkg::LVL_SUSPICIOUS;
			else
				w.level = fats_pkg::LVL_NORMAL;

			if (w.level == fats_pkg::LVL_DESTRUCTIVE)
				escal = 1'b1;
			if (w.level != fats_pkg::LVL_NORMAL) begin
				if (!alarm_on || w.level != alarm_level) begin
					w.new_alert = 1'b1;
					alarm_on    = 1'b1;
					alarm_level = w.level;
					alarm_seq++;
				end
			end else begin
				alarm_on    = 1'b0;
				alarm_level = fats_pkg::LVL_NORMAL;
				escal       = 1'b0;
			end
		end
		w.kind     = cmd;
		w.alert_id = alarm_seq;
		w.lost     = lost_sum;
		w.esc      = escal;
		return w;
	endfunction

	// ---------------------------------------------------------------
	// Monitor: takes both handshakes at the rising edge.
	// Input words are forecast from what was actually on the bus.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : monitor
		report_word_t want;
		ev_fire = (ev_if.valid === 1'b1) && (ev_if.ready === 1'b1);
		if (ev_fire) begin
			due_reports.push_back(forecast_report(fats_pkg::cmd_t'(ev_if.cmd), ev_if.tier,
				fats_pkg::kind_t'(ev_if.event_kind), ev_if.time_ms));
			void'(pending_words.pop_front());
		end
		if (rep_if.valid === 1'b1 && rep_if.ready === 1'b1) begin
			n_reports++;
			if (due_reports.size() == 0) begin
				note_mismatch("report word with nothing outstanding");
			end else begin
				want = due_reports.pop_front();
				check_field("report_kind", rep_if.report_kind, want.kind);
				check_field("burst_flag", rep_if.burst_flag, want.bflag);
				check_field("burst_count", rep_if.burst_count, want.bcount);
				check_field("burst_span_ms", rep_if.burst_span_ms, want.bspan);
				check_field("score", rep_if.score, want.score);
				check_field("level", rep_if.level, want.level);
				check_field("new_alert", rep_if.new_alert, want.new_alert);
				check_field("alert_id", rep_if.alert_id, want.alert_id);
				check_field("tiers_mask", rep_if.tiers_mask, want.mask);
				check_field("window_deletes", rep_if.window_deletes, want.wdel);
				check_field("lost_total", rep_if.lost_total, want.lost);
				check_field("escalation_flag", rep_if.escalation_flag, want.esc);
			end
		end
	end

	// ---------------------------------------------------------------
	// Driver: bursts of back-to-back words with random gaps between.
	// A word on the bus stays put until it is taken.
	// ---------------------------------------------------------------
	int run_left;
	int gap_left;

	always @(negedge clk) begin
		if (ev_if.valid === 1'b1 && !ev_fire) begin
			// held: word not yet taken
		end else if (pending_words.size() == 0 || gap_left > 0) begin
			ev_if.valid <= 1'b0;
			if (gap_left > 0)
				gap_left--;
		end else begin
			ev_if.valid      <= 1'b1;
			ev_if.cmd        <= pending_words[0].cmd;
			ev_if.tier       <= pending_words[0].tier;
			ev_if.event_kind <= pending_words[0].kind;
			ev_if.time_ms    <= pending_words[0].t_ms;
			if (run_left > 0) begin
				run_left--;
			end else begin
				run_left = $urandom_range(0, 15);
				// about a third of the bursts run straight into the next
				gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver: its own stall pattern, plus two long hold-offs that
	// back the pipeline up into the events channel.
	// ---------------------------------------------------------------
	rx_mode_t rx_mode;
	int       rx_mode_left;
	int       hold_left;
	int       holds_done;

	always @(negedge clk) begin : receiver
		logic rdy;
		rdy = 1'b0;
		if (hold_left > 0) begin
			hold_left--;
		end else if ((holds_done == 0 && n_reports >= HOLD_MARK_A) ||
			(holds_done == 1 && n_reports >= HOLD_MARK_B)) begin
			hold_left = LONG_HOLD;
			holds_done++;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(4, 40);
			end else begin
				rx_mode_left--;
			end
			case (rx_mode)
				RX_OPEN:   rdy = 1'b1;
				RX_COIN:   rdy = $urandom_range(0, 1);
				RX_MOSTLY: rdy = ($urandom_range(0, 4) != 0);
				default:   rdy = (rep_if.ready !== 1'b1);
			endcase
		end
		rep_if.ready <= rdy;
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic void push_word(input fats_pkg::cmd_t c, input logic [1:0] tr,
		input fats_pkg::kind_t k, input logic [31:0] t_ms);
		ev_word_t w;
		w.cmd  = c;
		w.tier = tr;
		w.kind = k;
		w.t_ms = t_ms;
		pending_words.push_back(w);
	endfunction

	// tick fields are don't-care, so fill them with noise
	function automatic void push_tick();
		push_word(fats_pkg::CMD_TICK, 2'($urandom_range(0, 3)),
			fats_pkg::kind_t'($urandom_range(0, 3)), $urandom);
	endfunction

	function automatic logic [1:0] pick_tier();
		if ($urandom_range(0, 15) == 0)
			return TIER_NONE;
		return 2'($urandom_range(0, 2));
	endfunction

	function automatic fats_pkg::kind_t pick_kind();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return fats_pkg::KIND_DELETE;
		else if (r < 7)
			return fats_pkg::KIND_MODIFY;
		else if (r < 9)
			return fats_pkg::KIND_RENAME;
		return fats_pkg::KIND_OTHER;
	endfunction

	// Random mix: mostly windows of events closed by a tick, runs of
	// high-tier deletes paced around the burst window, raw noise, bare ticks.
	task automatic gen_phase(input int target);
		int made;
		int seg;
		int n;
		int lim;
		int pace;
		made = 0;
		while (made < target) begin
			seg = $urandom_range(0, 99);
			if (seg < 50) begin
				n = ($urandom_range(0, 6) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 10);
				repeat (n) begin
					if ($urandom_range(0, 39) == 0)
						now_ms += $urandom;
					else
						now_ms += $urandom_range(0, 120);
					push_word(fats_pkg::CMD_EVENT, pick_tier(), pick_kind(), now_ms);
					made++;
				end
				push_tick();
				made++;
			end else if (seg < 72) begin
				lim  = (regs.burst_count_limit == 0) ? 1 : regs.burst_count_limit;
				// steps straddle window/limit so runs land on both sides
				pace = regs.burst_window_ms / lim + regs.burst_window_ms / (2 * lim) + 2;
				n = $urandom_range(2, 9);
				repeat (n) begin
					now_ms += $urandom_range(0, pace);
					push_word(fats_pkg::CMD_EVENT, fats_pkg::TIER_HIGH, fats_pkg::KIND_DELETE,
						now_ms);
					made++;
				end
				if ($urandom_range(0, 1) == 1) begin
					push_tick();
					made++;
				end
			end else if (seg < 90) begin
				push_word(fats_pkg::cmd_t'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
					fats_pkg::kind_t'($urandom_range(0, 3)), $urandom);
				made++;
			end else begin
				repeat ($urandom_range(1, 3)) begin
					push_tick();
					made++;
				end
			end
		end
	endtask

	// block until everything sent has been accepted and answered
	task automatic drain();
		while (pending_words.size() != 0 || due_reports.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// one register write; the shadow follows at the accepting edge
	task automatic write_reg(input logic [fats_pkg::CFG_IDX_W-1:0] idx,
		input logic [23:0] val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do
			@(posedge clk);
		while (cfg_if.ready !== 1'b1);
		case (idx)
			fats_pkg::REG_WT_HI:        regs.wt_hi             = val[3:0];
			fats_pkg::REG_WT_MID:       regs.wt_mid            = val[3:0];
			fats_pkg::REG_WT_LO:        regs.wt_lo             = val[3:0];
			fats_pkg::REG_SUSP_LEVEL:   regs.suspicious_level  = val;
			fats_pkg::REG_DESTR_LEVEL:  regs.destructive_level = val;
			fats_pkg::REG_BURST_LIMIT:  regs.burst_count_limit = val[7:0];
			fats_pkg::REG_BURST_WINDOW: regs.burst_window_ms   = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic load_regs(input logic [23:0] hw, input logic [23:0] mw,
		input logic [23:0] lw, input logic [23:0] susp, input logic [23:0] destr,
		input logic [23:0] lim, input logic [23:0] win);
		write_reg(fats_pkg::REG_WT_HI, hw);
		write_reg(fats_pkg::REG_WT_MID, mw);
		write_reg(fats_pkg::REG_WT_LO, lw);
		write_reg(fats_pkg::REG_SUSP_LEVEL, susp);
		write_reg(fats_pkg::REG_DESTR_LEVEL, destr);
		write_reg(fats_pkg::REG_BURST_LIMIT, lim);
		write_reg(fats_pkg::REG_BURST_WINDOW, win);
	endtask

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		ev_if.valid      = 1'b0;
		ev_if.cmd        = 1'b0;
		ev_if.tier       = '0;
		ev_if.event_kind = '0;
		ev_if.time_ms    = '0;
		rep_if.ready     = 1'b0;
		cfg_if.valid     = 1'b0;
		cfg_if.index     = '0;
		cfg_if.data      = '0;
		ev_fire          = 1'b0;
		fail_count       = 0;
		n_reports        = 0;
		run_left         = 0;
		gap_left         = 0;
		rx_mode          = RX_OPEN;
		rx_mode_left     = 0;
		hold_left        = 0;
		holds_done       = 0;

		// shadow at reset
		regs = '{wt_hi: fats_pkg::WT_HI_RST, wt_mid: fats_pkg::WT_MID_RST,
			wt_lo: fats_pkg::WT_LO_RST, suspicious_level: fats_pkg::SUSP_LEVEL_RST,
			destructive_level: fats_pkg::DESTR_LEVEL_RST,
			burst_count_limit: fats_pkg::BURST_LIMIT_RST,
			burst_window_ms: fats_pkg::BURST_WINDOW_RST};
		for (int i = 0; i < 9; i++)
			win_count[i] = '0;
		rush_n      = '0;
		rush_t0     = '0;
		alarm_on    = 1'b0;
		alarm_level = fats_pkg::LVL_NORMAL;
		alarm_seq   = '0;
		lost_sum    = '0;
		escal       = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// --- directed, reset register values ---
		push_tick();                                                       // empty window
		push_word(fats_pkg::CMD_EVENT, fats_pkg::TIER_HIGH, fats_pkg::KIND_DELETE, 32'd100);
		push_word(fats_pkg::CMD_EVENT, fats_pkg::TIER_HIGH, fats_pkg::KIND_DELETE, 32'd200);
		// third: burst
		push_word(fats_pkg::CMD_EVENT, fats_pkg::TIER_HIGH, fats_pkg::KIND_DELETE, 32'd300);
		push_word(fats_pkg::CMD_EVENT, fats_pkg::TIER_MEDIUM, fats_pkg::KIND_MODIFY, 32'd310);
		push_word(fats_pkg::CMD_EVENT, fats_pkg::TIER_LOW, fats_pkg::KIND_RENAME, 32'd320);
		// no such tier
		push_word(fats_pkg::CMD_EVENT, TIER_NONE, fats_pkg::KIND_DELETE, 32'd330);
		// ignored kind
		push_word(fats_pkg::CMD_EVENT, fats_pkg::TIER_HIGH, fats_pkg::KIND_OTHER, 32'd340);
		push_tick();                                                       // spread scaling
		push_word(fats_pkg::CMD_EVENT, fats_pkg::TIER_HIGH, fats_pkg::KIND_DELETE, 32'd1000);
		// too slow: restart
		push_word(fats_pkg::CMD_EVENT, fats_pkg::TIER_HIGH, fats_pkg::KIND_DELETE, 32'd1600);
		push_tick();
		// burst across the timestamp wrap
		push_word(fats_pkg::CMD_EVENT, fats_pkg::TIER_HIGH, fats_pkg::KIND_DELETE,
			32'hFFFF_FFF0);
		push_word(fats_pkg::CMD_EVENT, fats_pkg::TIER_HIGH, fats_pkg::KIND_DELETE,
			32'h0000_0010);
		push_word(fats_pkg::CMD_EVENT, fats_pkg::TIER_HIGH, fats_pkg::KIND_DELETE,
			32'h0000_0020);
		push_tick();
		push_tick();
		// tick with every field at its top value; fields are ignored
		push_word(fats_pkg::CMD_TICK, TIER_NONE, fats_pkg::KIND_OTHER, 32'hFFFF_FFFF);
		push_word(fats_pkg::CMD_EVENT, fats_pkg::TIER_LOW, fats_pkg::KIND_DELETE, 32'd0);
		push_word(fats_pkg::CMD_EVENT, fats_pkg::TIER_MEDIUM, fats_pkg::KIND_RENAME,
			32'hFFFF_FFFF);
		push_tick();
		drain();

		// --- random at reset values ---
		now_ms = 32'd2000;
		gen_phase(60);
		drain();

		// --- top weights, low thresholds, every high delete is a burst ---
		load_regs(24'd15, 24'd15, 24'd15, 24'd20, 24'd60, 24'd1, 24'd0);
		gen_phase(50);
		drain();

		// --- one busy window of medium deletes ---
		repeat (40) begin
			now_ms += $urandom_range(0, 3);
			push_word(fats_pkg::CMD_EVENT, fats_pkg::TIER_MEDIUM, fats_pkg::KIND_DELETE, now_ms);
		end
		push_word(fats_pkg::CMD_EVENT, fats_pkg::TIER_HIGH, fats_pkg::KIND_MODIFY, now_ms);
		push_tick();
		push_tick();
		drain();

		// --- zero weights and thresholds, widest burst limit and window ---
		load_regs(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd255, 24'd65535);
		// a long run of high deletes that stays short of the limit
		repeat (40) begin
			now_ms += $urandom_range(0, 200);
			push_word(fats_pkg::CMD_EVENT, fats_pkg::TIER_HIGH, fats_pkg::KIND_DELETE, now_ms);
		end
		gen_phase(50);
		drain();

		// --- unreachable thresholds, zero burst limit ---
		load_regs(24'($urandom), 24'($urandom), 24'($urandom), 24'hFF_FFFF, 24'hFF_FFFF,
			24'd0, 24'($urandom_range(0, 65535)));
		gen_phase(50);
		drain();

		// --- crossed thresholds: destructive below suspicious ---
		load_regs(24'd7, 24'd4, 24'd2, 24'd40, 24'd10, 24'd2, 24'd100);
		gen_phase(50);
		drain();

		// --- alert ID steps: each tick flips suspicious/destructive ---
		write_reg(REG_SPARE, 24'($urandom));
		load_regs(24'd1, 24'd1, 24'd1, 24'd0, 24'd1, 24'd3, 24'd500);
		repeat (20) begin
			push_tick();
			now_ms += $urandom_range(0, 50);
			push_word(fats_pkg::CMD_EVENT, fats_pkg::TIER_LOW, fats_pkg::KIND_MODIFY, now_ms);
			push_tick();
		end
		drain();

		// --- random registers, full data words (upper bits dropped) ---
		load_regs(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom_range(0, 300)),
			24'($urandom_range(0, 600)), 24'($urandom_range(1, 6)),
			24'($urandom_range(0, 1500)));
		gen_phase(60);
		drain();

		// let the pipeline settle; any stray word shows up as a mismatch
		repeat (12) @(posedge clk);
		if (due_reports.size() != 0)
			note_mismatch("expected report words never arrived");
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#200_000;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
src/fats_pkg.sv
src/fats_if.sv
src/fats_cfg.sv
src/fats_window.sv
src/fats_score.sv
src/fats_alert.sv
src/file_activity_threat_scorer.sv
sim/file_activity_threat_scorer_tb.sv
